[src/least_squares_line_fit_defines.svh]
// ----------------------------------------------------------------------------
// least_squares_line_fit_defines.svh
// Assertion macros shared by the line-fit block.
// ----------------------------------------------------------------------------
`ifndef LEAST_SQUARES_LINE_FIT_DEFINES_SVH
`define LEAST_SQUARES_LINE_FIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LSFIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LSFIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lsfit_pkg.sv]
// ----------------------------------------------------------------------------
// lsfit_pkg
// Widths, operand codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lsfit_pkg;

    localparam int CNT_W   = 17;
    localparam int SX_W    = 33;
    localparam int SXX_W   = 47;
    localparam int SXY_W   = 48;
    localparam int RES_W   = 48;
    localparam int OPND_W  = 49;   // signed operand into the serial multiplier
    localparam int MAG_W   = 48;
    localparam int PROD_W  = 96;
    localparam int NUM_W   = 80;   // signed numerator / denominator accumulator
    localparam int DEN_W   = 64;
    localparam int MUL_STEPS = 48;
    localparam int MCNT_W  = 6;

    typedef enum logic [2:0] {
        SEL_N_SXX,
        SEL_SX_SX,
        SEL_N_SXY,
        SEL_SX_SY,
        SEL_SXX_SY,
        SEL_SXY_SX
    } mul_sel_t;

    typedef struct packed {
        logic     acc_en;
        logic     acc_clear;
        logic     mul_start;
        logic     mul_first;
        logic     mul_sub;
        mul_sel_t mul_sel;
        logic     latch_den;
        logic     zero_res;
        logic     div_start;
        logic     div_to_slope;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic den_zero;
    } stat_t;

endpackage

[src/lsfit_dp.sv]
// ----------------------------------------------------------------------------
// lsfit_dp
// Running sums, shift-add multiplier, restoring divider and result registers.
// ----------------------------------------------------------------------------
module lsfit_dp #(
    parameter int MAX_POINTS    = 65536,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lsfit_pkg::cmd_t                    cmd,
    output lsfit_pkg::stat_t                   stat,
    input  logic signed [15:0]                 x_value,
    input  logic signed [15:0]                 y_value,
    output logic signed [lsfit_pkg::RES_W-1:0] slope,
    output logic signed [lsfit_pkg::RES_W-1:0] intercept,
    output logic [lsfit_pkg::CNT_W-1:0]        point_count,
    output logic                               degenerate
);
    import lsfit_pkg::*;

    localparam int DIV_W  = NUM_W - 1 + FRACTION_BITS;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    // accumulators
    logic [CNT_W-1:0]        count_reg;
    logic signed [SX_W-1:0]  sum_x_reg;
    logic signed [SX_W-1:0]  sum_y_reg;
    logic [SXX_W-1:0]        sum_xx_reg;
    logic signed [SXY_W-1:0] sum_xy_reg;

    logic signed [SAMPLE_BITS-1:0] x_smp;
    logic signed [SAMPLE_BITS-1:0] y_smp;
    logic signed [15:0]            x_s;
    logic signed [15:0]            y_s;
    logic signed [31:0]            xx;
    logic signed [31:0]            xy;

    assign x_smp = x_value[SAMPLE_BITS-1:0];
    assign y_smp = y_value[SAMPLE_BITS-1:0];
    assign x_s   = 16'(x_smp);
    assign y_s   = 16'(y_smp);
    assign xx    = x_s * x_s;
    assign xy    = x_s * y_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_xy_reg <= '0;
        end
        else if (cmd.acc_clear)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_xy_reg <= '0;
        end
        else if (cmd.acc_en && (count_reg < CNT_W'(MAX_POINTS)))
        begin
            count_reg  <= count_reg + 1'b1;
            sum_x_reg  <= sum_x_reg + SX_W'(x_s);
            sum_y_reg  <= sum_y_reg + SX_W'(y_s);
            sum_xx_reg <= sum_xx_reg + SXX_W'(xx);
            sum_xy_reg <= sum_xy_reg + SXY_W'(xy);
        end
    end

    // operand select
    logic signed [OPND_W-1:0] op_n;
    logic signed [OPND_W-1:0] op_sx;
    logic signed [OPND_W-1:0] op_sy;
    logic signed [OPND_W-1:0] op_sxx;
    logic signed [OPND_W-1:0] op_sxy;
    logic signed [OPND_W-1:0] op_a;
    logic signed [OPND_W-1:0] op_b;
    logic signed [OPND_W-1:0] op_a_neg;
    logic signed [OPND_W-1:0] op_b_neg;
    logic [MAG_W-1:0]         mag_a;
    logic [MAG_W-1:0]         mag_b;

    assign op_n   = OPND_W'($signed({1'b0, count_reg}));
    assign op_sxx = OPND_W'($signed({1'b0, sum_xx_reg}));
    assign op_sx  = OPND_W'(sum_x_reg);
    assign op_sy  = OPND_W'(sum_y_reg);
    assign op_sxy = OPND_W'(sum_xy_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            SEL_N_SXX:  begin op_a = op_n;   op_b = op_sxx; end
            SEL_SX_SX:  begin op_a = op_sx;  op_b = op_sx;  end
            SEL_N_SXY:  begin op_a = op_n;   op_b = op_sxy; end
            SEL_SX_SY:  begin op_a = op_sx;  op_b = op_sy;  end
            SEL_SXX_SY: begin op_a = op_sxx; op_b = op_sy;  end
            SEL_SXY_SX: begin op_a = op_sxy; op_b = op_sx;  end
            default:    begin op_a = '0;     op_b = '0;     end
        endcase
    end

    assign op_a_neg = -op_a;
    assign op_b_neg = -op_b;
    assign mag_a = op_a[OPND_W-1] ? MAG_W'(op_a_neg) : MAG_W'(op_a);
    assign mag_b = op_b[OPND_W-1] ? MAG_W'(op_b_neg) : MAG_W'(op_b);

    // shift-add multiplier
    logic [PROD_W-1:0]       prod_reg;
    logic [PROD_W-1:0]       mcand_reg;
    logic [MAG_W-1:0]        mplier_reg;
    logic [MCNT_W-1:0]       mcnt_reg;
    logic                    mneg_reg;
    logic                    mul_done_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic signed [NUM_W-1:0] prod_s;

    assign prod_s = mneg_reg ? -$signed(NUM_W'(prod_reg)) : $signed(NUM_W'(prod_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg     <= '0;
            mul_done_reg <= 1'b0;
        end
        else
        begin
            mul_done_reg <= 1'b0;
            if (cmd.mul_start)
            begin
                mcnt_reg <= MCNT_W'(MUL_STEPS);
            end
            else if (mcnt_reg != '0)
            begin
                mcnt_reg     <= mcnt_reg - 1'b1;
                mul_done_reg <= (mcnt_reg == MCNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            prod_reg   <= '0;
            mcand_reg  <= PROD_W'(mag_a);
            mplier_reg <= mag_b;
            mneg_reg   <= op_a[OPND_W-1] ^ op_b[OPND_W-1] ^ cmd.mul_sub;
            if (cmd.mul_first)
            begin
                num_reg <= '0;
            end
        end
        else
        begin
            if (mcnt_reg != '0)
            begin
                if (mplier_reg[0])
                begin
                    prod_reg <= prod_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            if (mul_done_reg)
            begin
                num_reg <= num_reg + prod_s;
            end
        end
    end

    // restoring divider: quotient bits shift into the dividend register
    logic [DEN_W-1:0]  den_reg;
    logic              deg_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              dneg_reg;
    logic              div_fin_reg;
    logic [DEN_W:0]    rem_sh;
    logic              rem_ge;
    logic [DEN_W:0]    rem_sub;
    logic [NUM_W-2:0]  num_mag;
    logic signed [NUM_W-1:0] num_neg;

    assign num_neg = -num_reg;
    assign num_mag = num_reg[NUM_W-1] ? num_neg[NUM_W-2:0] : num_reg[NUM_W-2:0];
    assign rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg    <= '0;
            div_fin_reg <= 1'b0;
        end
        else
        begin
            div_fin_reg <= 1'b0;
            if (cmd.div_start)
            begin
                dcnt_reg <= DCNT_W'(DIV_W);
            end
            else if (dcnt_reg != '0)
            begin
                dcnt_reg    <= dcnt_reg - 1'b1;
                div_fin_reg <= (dcnt_reg == DCNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg  <= DIV_W'(num_mag) << FRACTION_BITS;
            rem_reg  <= '0;
            dneg_reg <= num_reg[NUM_W-1];
        end
        else if (dcnt_reg != '0)
        begin
            rem_reg <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], rem_ge};
        end
    end

    // round half away from zero, then saturate
    logic             rnd_up;
    logic [DIV_W:0]   q_rnd;
    logic [RES_W-1:0] q_lim;
    logic [RES_W-1:0] q_mag;
    logic [RES_W-1:0] q_mag_neg;
    logic [RES_W-1:0] q_res;

    assign rnd_up    = {rem_reg, 1'b0} >= {1'b0, den_reg};
    assign q_rnd     = {1'b0, dvd_reg} + (DIV_W + 1)'(rnd_up);
    assign q_lim     = dneg_reg ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    assign q_mag     = (q_rnd > (DIV_W + 1)'(q_lim)) ? q_lim : q_rnd[RES_W-1:0];
    assign q_mag_neg = -q_mag;
    assign q_res     = dneg_reg ? q_mag_neg : q_mag;

    logic signed [RES_W-1:0] slope_res_reg;
    logic signed [RES_W-1:0] icpt_res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_den)
        begin
            den_reg <= num_reg[DEN_W-1:0];
            deg_reg <= (num_reg == '0);
        end
        if (cmd.zero_res)
        begin
            slope_res_reg <= '0;
            icpt_res_reg  <= '0;
        end
        else if (div_fin_reg)
        begin
            if (cmd.div_to_slope)
            begin
                slope_res_reg <= $signed(q_res);
            end
            else
            begin
                icpt_res_reg <= $signed(q_res);
            end
        end
        if (cmd.load_out)
        begin
            slope       <= slope_res_reg;
            intercept   <= icpt_res_reg;
            point_count <= count_reg;
            degenerate  <= deg_reg;
        end
    end

    assign stat.mul_done = mul_done_reg;
    assign stat.div_done = div_fin_reg;
    assign stat.den_zero = (num_reg == '0);

endmodule

[src/lsfit_ctrl.sv]
// ----------------------------------------------------------------------------
// lsfit_ctrl
// Sequencer: accumulate, form denominator, two numerators, two divides, emit.
// ----------------------------------------------------------------------------
module lsfit_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             last_point,
    output logic             out_valid,
    input  logic             out_stall,
    input  lsfit_pkg::stat_t stat,
    output lsfit_pkg::cmd_t  cmd
);
    import lsfit_pkg::*;

    typedef enum logic [3:0] {
        S_ACC,
        S_DEN_A,
        S_DEN_B,
        S_DEN_CHK,
        S_SLP_A,
        S_SLP_B,
        S_SLP_DIV,
        S_ICP_A,
        S_ICP_B,
        S_ICP_DIV,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   start_reg;
    logic   start_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !(out_valid_reg && out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_ACC:     if (in_valid && last_point) state_next = S_DEN_A;
            S_DEN_A:   if (stat.mul_done) state_next = S_DEN_B;
            S_DEN_B:   if (stat.mul_done) state_next = S_DEN_CHK;
            S_DEN_CHK: state_next = stat.den_zero ? S_EMIT : S_SLP_A;
            S_SLP_A:   if (stat.mul_done) state_next = S_SLP_B;
            S_SLP_B:   if (stat.mul_done) state_next = S_SLP_DIV;
            S_SLP_DIV: if (stat.div_done) state_next = S_ICP_A;
            S_ICP_A:   if (stat.mul_done) state_next = S_ICP_B;
            S_ICP_B:   if (stat.mul_done) state_next = S_ICP_DIV;
            S_ICP_DIV: if (stat.div_done) state_next = S_EMIT;
            S_EMIT:    if (out_free) state_next = S_ACC;
            default:   state_next = S_ACC;
        endcase
        // one start pulse on entry to each multiply or divide step
        start_next = (state_next != state_reg) && (state_next != S_DEN_CHK)
                     && (state_next != S_EMIT) && (state_next != S_ACC);
        out_valid_next = cmd.load_out || (out_valid_reg && out_stall);
    end

    always_comb
    begin
        cmd = '0;
        cmd.acc_en       = (state_reg == S_ACC) && in_valid;
        cmd.load_out     = (state_reg == S_EMIT) && out_free;
        cmd.acc_clear    = cmd.load_out;
        cmd.mul_first    = (state_reg == S_DEN_A) || (state_reg == S_SLP_A)
                           || (state_reg == S_ICP_A);
        cmd.mul_sub      = (state_reg == S_DEN_B) || (state_reg == S_SLP_B)
                           || (state_reg == S_ICP_B);
        cmd.mul_start    = start_reg && (cmd.mul_first || cmd.mul_sub);
        cmd.div_start    = start_reg && ((state_reg == S_SLP_DIV) || (state_reg == S_ICP_DIV));
        cmd.div_to_slope = (state_reg == S_SLP_DIV);
        cmd.latch_den    = (state_reg == S_DEN_CHK);
        cmd.zero_res     = (state_reg == S_DEN_CHK) && stat.den_zero;
        case (state_reg)
            S_DEN_A: cmd.mul_sel = SEL_N_SXX;
            S_DEN_B: cmd.mul_sel = SEL_SX_SX;
            S_SLP_A: cmd.mul_sel = SEL_N_SXY;
            S_SLP_B: cmd.mul_sel = SEL_SX_SY;
            S_ICP_A: cmd.mul_sel = SEL_SXX_SY;
            S_ICP_B: cmd.mul_sel = SEL_SXY_SX;
            default: cmd.mul_sel = SEL_N_SXX;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_ACC);
    assign out_valid = out_valid_reg;

endmodule

[src/least_squares_line_fit.sv]
// ----------------------------------------------------------------------------
// least_squares_line_fit
// Streaming least-squares line fit with fixed-point slope and intercept.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while in_stall is low and folded into the
// count and the sums of x, y, x*x and x*y. A point marked last starts the fit
// and the input stalls until it is done: six 48-step shift-add multiplies
// form the denominator and the two numerators, and two restoring divides of
// 79+FRACTION_BITS steps each give slope and intercept. When the denominator
// is zero, the fit stops after it and emits zero results. The output
// register lets the next data set accumulate while the result waits to be
// taken.
module least_squares_line_fit #(
    parameter int MAX_POINTS    = 65536,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [15:0]                 x_value,
    input  logic signed [15:0]                 y_value,
    input  logic                               last_point,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [lsfit_pkg::RES_W-1:0] slope,
    output logic signed [lsfit_pkg::RES_W-1:0] intercept,
    output logic [lsfit_pkg::CNT_W-1:0]        point_count,
    output logic                               degenerate
);
    import lsfit_pkg::*;

    `include "least_squares_line_fit_defines.svh"

    cmd_t  cmd;
    stat_t stat;

    lsfit_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .last_point (last_point),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    lsfit_dp #(
        .MAX_POINTS    (MAX_POINTS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .x_value     (x_value),
        .y_value     (y_value),
        .slope       (slope),
        .intercept   (intercept),
        .point_count (point_count),
        .degenerate  (degenerate)
    );

    `LSFIT_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && last_point, in_stall, "fit not started")
    `LSFIT_ASSERT_NOW(a_degen_zero, out_valid && degenerate, (slope | intercept) == '0, "nonzero fit")
    `LSFIT_ASSERT_NOW(a_mul_div_excl, stat.mul_done, !stat.div_done, "mul and div done together")

endmodule
